// File: hdl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// No dependencies; used by every module under hdl.
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int POOL_PAGES = 4096;
    localparam int MAX_ORDER  = 10;
    localparam int IDX_W      = $clog2(POOL_PAGES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ORD_W      = 4;
    localparam int FC_W       = $clog2(POOL_PAGES + 1);
    localparam int PAGE_W     = 20;
    localparam int GROUPS     = POOL_PAGES / (1 << MAX_ORDER);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOMEM    = 2'd1,
        ST_NOTALLOC = 2'd2,
        ST_OUTSIDE  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_FIND,
        OP_SCAN,
        OP_TAKE,
        OP_SPLIT,
        OP_FRD,
        OP_FVER,
        OP_MRD,
        OP_MCHK,
        OP_FFIN
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    report;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic req_bad;
        logic outside;
        logic find_hit;
        logic find_end;
        logic scan_done;
        logic scan_found;
        logic split_more;
        logic ver_ok;
        logic merge_stop;
        logic bud_free;
    } t_stat;

    typedef struct packed {
        logic             hv;
        logic             al;
        logic [ORD_W-1:0] ord;
    } t_rec;

endpackage

// File: hdl/bpa_datapath.sv
// Datapath: page record memory, free counts, search and merge registers, result registers.
// Depends on bpa_pkg; driven by bpa_ctrl through t_cmd.
`timescale 1ns / 1ps
module bpa_datapath import bpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PAGE_W-1:0] i_cfg_data,
    input  logic              i_mode,
    input  logic [ORD_W-1:0]  i_order,
    input  logic [PAGE_W-1:0] i_page_number,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [PAGE_W-1:0] o_result_page,
    output logic [ORD_W-1:0]  o_final_order
);

    t_rec mem [POOL_PAGES];
    t_rec r_rd;

    logic [PAGE_W-1:0] r_base;
    logic              r_mode;
    logic [ORD_W-1:0]  r_req;
    logic [PAGE_W-1:0] r_page;
    logic [ORD_W-1:0]  r_cur;
    logic [CNT_W-1:0]  r_scan;
    logic [IDX_W-1:0]  r_chk;
    logic              r_chk_v;
    logic [IDX_W-1:0]  r_pick;
    logic              r_found;
    logic [IDX_W-1:0]  r_idx;
    logic [ORD_W-1:0]  r_lvl;
    logic [CNT_W-1:0]  r_clr;
    logic [FC_W-1:0]   r_fc [MAX_ORDER+1];
    logic              r_done;
    logic [1:0]        r_status;
    logic [PAGE_W-1:0] r_res_page;
    logic [ORD_W-1:0]  r_res_ord;

    logic [PAGE_W:0]   diff;
    logic [CNT_W-1:0]  step;
    logic [CNT_W-1:0]  bud;
    logic [ORD_W-1:0]  split_ord;
    logic [IDX_W-1:0]  half;
    logic              match;
    logic              first_mode;
    logic              we;
    logic [IDX_W-1:0]  wa;
    logic [IDX_W-1:0]  ra;
    t_rec              wd;
    logic              clr_hv;

    assign diff       = {1'b0, r_page} - {1'b0, r_base};
    assign step       = CNT_W'(1) << r_cur;
    assign bud        = {1'b0, r_idx} ^ (CNT_W'(1) << r_lvl);
    assign split_ord  = r_cur - ORD_W'(1);
    assign half       = r_pick + (IDX_W'(1) << split_ord);
    assign match      = r_rd.hv && !r_rd.al && (r_rd.ord == r_cur);
    assign first_mode = (r_cur != r_req) || (r_cur == '0);
    assign clr_hv     = (r_clr[MAX_ORDER-1:0] == '0) &&
                        ((r_clr >> MAX_ORDER) < CNT_W'(GROUPS));

    always_comb begin
        o_stat.clear_last = (r_clr == CNT_W'(POOL_PAGES - 1));
        o_stat.is_free    = r_mode;
        o_stat.req_bad    = (r_req > ORD_W'(MAX_ORDER));
        o_stat.outside    = (r_page < r_base) || (diff >= (PAGE_W+1)'(POOL_PAGES));
        o_stat.find_hit   = (r_fc[r_cur] != '0);
        o_stat.find_end   = (r_cur == ORD_W'(MAX_ORDER));
        o_stat.scan_done  = (r_chk_v && match && first_mode) ||
                            (!r_chk_v && (r_scan >= CNT_W'(POOL_PAGES)));
        o_stat.scan_found = r_found || (r_chk_v && match);
        o_stat.split_more = (r_cur > r_req);
        o_stat.ver_ok     = r_rd.hv && r_rd.al && (r_rd.ord == r_req);
        o_stat.merge_stop = (r_lvl >= ORD_W'(MAX_ORDER)) || (bud >= CNT_W'(POOL_PAGES));
        o_stat.bud_free   = r_rd.hv && !r_rd.al && (r_rd.ord == r_lvl);
    end

    always_comb begin
        we = 1'b0;
        wa = r_idx;
        wd = '{hv: 1'b0, al: 1'b0, ord: r_lvl};
        ra = r_scan[IDX_W-1:0];
        case (i_cmd.op)
            OP_CLEAR: begin
                we = 1'b1;
                wa = r_clr[IDX_W-1:0];
                wd = '{hv: clr_hv, al: 1'b0, ord: ORD_W'(MAX_ORDER)};
            end
            OP_TAKE: begin
                we = 1'b1;
                wa = r_pick;
                wd = '{hv: 1'b1, al: 1'b1, ord: r_req};
            end
            OP_SPLIT: begin
                we = 1'b1;
                wa = half;
                wd = '{hv: 1'b1, al: 1'b0, ord: split_ord};
            end
            OP_FRD: begin
                ra = diff[IDX_W-1:0];
            end
            OP_FVER: begin
                we = o_stat.ver_ok;
            end
            OP_MRD: begin
                ra = bud[IDX_W-1:0];
            end
            OP_MCHK: begin
                we = o_stat.bud_free;
                wa = bud[IDX_W-1:0];
            end
            OP_FFIN: begin
                we = 1'b1;
                wd = '{hv: 1'b1, al: 1'b0, ord: r_lvl};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_chk_v <= 1'b0;
            r_found <= 1'b0;
            for (int k = 0; k <= MAX_ORDER; k++) begin
                r_fc[k] <= (k == MAX_ORDER) ? FC_W'(GROUPS) : '0;
            end
        end else begin
            r_done <= i_cmd.report;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_clr <= r_clr + CNT_W'(1);
                end
                OP_LATCH: begin
                    r_mode <= i_mode;
                    r_req  <= i_order;
                    r_page <= i_page_number;
                    r_cur  <= i_order;
                end
                OP_FIND: begin
                    if (!o_stat.find_hit) begin
                        r_cur <= r_cur + ORD_W'(1);
                    end
                    r_scan  <= '0;
                    r_chk_v <= 1'b0;
                    r_found <= 1'b0;
                end
                OP_SCAN: begin
                    if (r_chk_v && match) begin
                        r_pick  <= r_chk;
                        r_found <= 1'b1;
                    end
                    if (r_scan < CNT_W'(POOL_PAGES)) begin
                        r_chk   <= r_scan[IDX_W-1:0];
                        r_chk_v <= 1'b1;
                        r_scan  <= r_scan + step;
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                end
                OP_TAKE: begin
                    r_fc[r_cur] <= r_fc[r_cur] - FC_W'(1);
                end
                OP_SPLIT: begin
                    r_fc[split_ord] <= r_fc[split_ord] + FC_W'(1);
                    r_cur           <= split_ord;
                end
                OP_FRD: begin
                    r_idx <= diff[IDX_W-1:0];
                    r_lvl <= r_req;
                end
                OP_MCHK: begin
                    if (o_stat.bud_free) begin
                        r_fc[r_lvl] <= r_fc[r_lvl] - FC_W'(1);
                        r_idx       <= r_idx & bud[IDX_W-1:0];
                        r_lvl       <= r_lvl + ORD_W'(1);
                    end
                end
                OP_FFIN: begin
                    r_fc[r_lvl] <= r_fc[r_lvl] + FC_W'(1);
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_status <= i_cmd.status;
            if (i_cmd.status != ST_OK) begin
                r_res_page <= '0;
                r_res_ord  <= '0;
            end else if (r_mode) begin
                r_res_page <= r_base + PAGE_W'(r_idx);
                r_res_ord  <= r_lvl;
            end else begin
                r_res_page <= r_base + PAGE_W'(r_pick);
                r_res_ord  <= r_req;
            end
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_result_page = r_res_page;
    assign o_final_order = r_res_ord;

endmodule

// File: hdl/bpa_ctrl.sv
// Controller state machine: sequences clear, allocate search and split, free check and merge.
// Depends on bpa_pkg; drives bpa_datapath through t_cmd.
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_DISP  = 12'b000000000100,
        S_FIND  = 12'b000000001000,
        S_SCAN  = 12'b000000010000,
        S_TAKE  = 12'b000000100000,
        S_SPLIT = 12'b000001000000,
        S_FRD   = 12'b000010000000,
        S_FVER  = 12'b000100000000,
        S_MRD   = 12'b001000000000,
        S_MCHK  = 12'b010000000000,
        S_FFIN  = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.report = 1'b0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_stat.is_free) begin
                    if (i_stat.req_bad) begin
                        o_cmd.report = 1'b1;
                        o_cmd.status = ST_NOMEM;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_FIND;
                    end
                end else if (i_stat.outside) begin
                    o_cmd.report = 1'b1;
                    o_cmd.status = ST_OUTSIDE;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_FIND: begin
                o_cmd.op = OP_FIND;
                if (i_stat.find_hit) begin
                    n_state = S_SCAN;
                end else if (i_stat.find_end) begin
                    o_cmd.report = 1'b1;
                    o_cmd.status = ST_NOMEM;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_stat.scan_done) begin
                    if (i_stat.scan_found) begin
                        n_state = S_TAKE;
                    end else begin
                        o_cmd.report = 1'b1;
                        o_cmd.status = ST_NOMEM;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_TAKE: begin
                o_cmd.op = OP_TAKE;
                n_state  = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_stat.split_more) begin
                    o_cmd.op = OP_SPLIT;
                end else begin
                    o_cmd.report = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FRD: begin
                o_cmd.op = OP_FRD;
                n_state  = S_FVER;
            end
            S_FVER: begin
                o_cmd.op = OP_FVER;
                if (i_stat.ver_ok) begin
                    n_state = S_MRD;
                end else begin
                    o_cmd.report = 1'b1;
                    o_cmd.status = ST_NOTALLOC;
                    n_state      = S_IDLE;
                end
            end
            S_MRD: begin
                if (i_stat.merge_stop) begin
                    n_state = S_FFIN;
                end else begin
                    o_cmd.op = OP_MRD;
                    n_state  = S_MCHK;
                end
            end
            S_MCHK: begin
                o_cmd.op = OP_MCHK;
                n_state  = i_stat.bud_free ? S_MRD : S_FFIN;
            end
            S_FFIN: begin
                o_cmd.op     = OP_FFIN;
                o_cmd.report = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hdl/buddy_page_allocator_core.sv
// Top level of the buddy page allocator: controller and datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
// Request channel: drive start with mode, order and page_number; the request is
// taken at a rising edge where start is high and busy is low. Allocate ignores
// page_number; free gives the absolute first page of the block.
// Result channel: o_done is high for exactly one cycle with o_status,
// o_result_page and o_final_order; the receiver cannot stall it.
// Configuration: i_cfg_we writes i_cfg_data into the pool base page register.
// Free checks the block record, then examines one buddy after another and
// merges while the buddy is free, up to MAX_ORDER or the end of the pool.
// Allocate searches the free counts upward from the requested order, scans
// that order's block heads, takes one and splits it down a level at a time;
// the scan reads one page record a cycle and stops at the first free head when
// the block will be split or the order is 0, else it takes the last one. The
// single read port of the record memory sets the scan rate.
// One request at a time; busy stays high until o_done. Reset: a clearing pass
// over all records, busy high, leaves the pool free as max-order blocks.
`timescale 1ns / 1ps
module buddy_page_allocator_core import bpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_mode,
    input  logic [ORD_W-1:0]  i_order,
    input  logic [PAGE_W-1:0] i_page_number,
    input  logic              i_cfg_we,
    input  logic [PAGE_W-1:0] i_cfg_data,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [PAGE_W-1:0] o_result_page,
    output logic [ORD_W-1:0]  o_final_order
);

    t_cmd  cmd;
    t_stat stat;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bpa_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_order       (i_order),
        .i_page_number (i_page_number),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_result_page (o_result_page),
        .o_final_order (o_final_order)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for buddy_page_allocator_core: a queue-fed driver,
// a result monitor and an in-order page pool predictor. Depends on bpa_pkg.
`timescale 1ns / 1ps
module tb;
    import bpa_pkg::*;

    localparam bit MODE_ALLOC = 1'b0;
    localparam bit MODE_FREE  = 1'b1;
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int PHASE_ITEMS = 270;

    typedef struct {
        bit              mode;
        bit [ORD_W-1:0]  order;
        bit [PAGE_W-1:0] page;
    } t_request;

    typedef struct {
        t_status         status;
        bit [PAGE_W-1:0] page;
        bit [ORD_W-1:0]  order;
    } t_outcome;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_mode;
    logic [ORD_W-1:0]  i_order;
    logic [PAGE_W-1:0] i_page_number;
    logic              i_cfg_we;
    logic [PAGE_W-1:0] i_cfg_data;
    logic              o_done;
    logic [1:0]        o_status;
    logic [PAGE_W-1:0] o_result_page;
    logic [ORD_W-1:0]  o_final_order;

    buddy_page_allocator_core dut (.*);

    t_request pending_requests[$];
    t_outcome expected_outcomes[$];
    int       live_idx[$];
    int       live_ord[$];
    int       errors = 0;
    int       watchdog = 0;
    int       wait_left = 0;
    bit       burst_mode = 0;

    bit [ORD_W-1:0]  pool_order[POOL_PAGES];
    bit              pool_head[POOL_PAGES];
    bit              pool_used[POOL_PAGES];
    int unsigned     free_blocks[MAX_ORDER+1];
    bit [PAGE_W-1:0] pool_base;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit pool_free_head(int i, int o);
        return i < POOL_PAGES && pool_head[i] && pool_order[i] == o && !pool_used[i];
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < POOL_PAGES; i++) begin
            pool_order[i] = 0;
            pool_head[i] = 0;
            pool_used[i] = 0;
        end
        foreach (free_blocks[o]) free_blocks[o] = 0;
        for (int i = 0; i + (1 << MAX_ORDER) <= POOL_PAGES; i += (1 << MAX_ORDER)) begin
            pool_head[i] = 1;
            pool_order[i] = ORD_W'(MAX_ORDER);
            free_blocks[MAX_ORDER]++;
        end
        pool_base = 0;
    endfunction

    // Apply one request to the pool; idx is the block head on success, else -1.
    function automatic t_outcome pool_apply(t_request r, output int idx);
        t_outcome res;
        int cur, pick, lvl, bud;
        bit found;
        bit [PAGE_W-1:0] rel;
        res = '{ST_OK, 0, 0};
        idx = -1;
        if (r.mode == MODE_ALLOC) begin
            if (r.order > MAX_ORDER) begin
                res.status = ST_NOMEM;
                return res;
            end
            for (cur = r.order; cur <= MAX_ORDER; cur++)
                if (free_blocks[cur] != 0) break;
            found = 0;
            pick = 0;
            if (cur <= MAX_ORDER) begin
                for (int i = 0; i < POOL_PAGES; i += (1 << cur)) begin
                    if (pool_free_head(i, cur)) begin
                        pick = i;
                        found = 1;
                        if (cur != r.order || cur == 0) break;
                    end
                end
            end
            if (!found) begin
                res.status = ST_NOMEM;
                return res;
            end
            free_blocks[cur]--;
            pool_order[pick] = r.order;
            pool_used[pick] = 1;
            while (cur > r.order) begin
                cur--;
                if (pick + (1 << cur) < POOL_PAGES) begin
                    pool_head[pick + (1 << cur)] = 1;
                    pool_order[pick + (1 << cur)] = ORD_W'(cur);
                    pool_used[pick + (1 << cur)] = 0;
                    free_blocks[cur]++;
                end
            end
            res.page = PAGE_W'(pool_base + pick);
            res.order = r.order;
            idx = pick;
            return res;
        end
        rel = r.page - pool_base;
        if (r.page < pool_base || rel >= POOL_PAGES) begin
            res.status = ST_OUTSIDE;
            return res;
        end
        pick = int'(rel);
        if (!pool_head[pick] || !pool_used[pick] || pool_order[pick] != r.order) begin
            res.status = ST_NOTALLOC;
            return res;
        end
        pool_used[pick] = 0;
        pool_head[pick] = 0;
        lvl = r.order;
        while (lvl < MAX_ORDER) begin
            bud = pick ^ (1 << lvl);
            if (!pool_free_head(bud, lvl)) break;
            pool_head[bud] = 0;
            free_blocks[lvl]--;
            pick = pick & bud;
            lvl++;
        end
        pool_head[pick] = 1;
        pool_order[pick] = ORD_W'(lvl);
        pool_used[pick] = 0;
        free_blocks[lvl]++;
        res.page = PAGE_W'(pool_base + pick);
        res.order = ORD_W'(lvl);
        idx = pick;
        return res;
    endfunction

    task automatic issue(bit mode, int ord, bit [PAGE_W-1:0] page);
        t_request r;
        t_outcome res;
        int idx;
        r = '{mode, ord[ORD_W-1:0], page};
        res = pool_apply(r, idx);
        if (res.status == ST_OK) begin
            if (mode == MODE_ALLOC) begin
                live_idx.push_back(idx);
                live_ord.push_back(ord);
            end
        end
        pending_requests.push_back(r);
        expected_outcomes.push_back(res);
    endtask

    task automatic free_live(int k, bit wrong_order);
        int ord;
        ord = live_ord[k];
        if (wrong_order) begin
            ord = (ord + $urandom_range(1, 15)) % 16;
            issue(MODE_FREE, ord, PAGE_W'(pool_base + live_idx[k]));
        end else begin
            issue(MODE_FREE, ord, PAGE_W'(pool_base + live_idx[k]));
            live_idx.delete(k);
            live_ord.delete(k);
        end
    endtask

    function automatic int draw_order();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 10) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, MAX_ORDER);
        return $urandom_range(MAX_ORDER + 1, 15);
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) begin
            if (live_idx.size() == 0 || r < 44)
                issue(MODE_ALLOC, draw_order(), PAGE_W'($urandom));
            else
                free_live($urandom_range(0, live_idx.size() - 1), 0);
        end else if (r < 92 && live_idx.size() != 0) begin
            free_live($urandom_range(0, live_idx.size() - 1), 1);
        end else if (r < 96) begin
            issue(MODE_FREE, $urandom_range(0, 15),
                  PAGE_W'(pool_base + $urandom_range(0, POOL_PAGES - 1)));
        end else begin
            issue(MODE_FREE, $urandom_range(0, 15), PAGE_W'($urandom));
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || start)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_base(bit [PAGE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pool_base = value;
    endtask

    // Driver: hold each request until taken, then wait a drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_mode <= 1'b0;
            i_order <= '0;
            i_page_number <= '0;
        end else if (!start || !busy) begin
            if (wait_left > 0) begin
                wait_left <= wait_left - 1;
                start <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                t_request r;
                r = pending_requests.pop_front();
                i_mode <= r.mode;
                i_order <= r.order;
                i_page_number <= r.page;
                start <= 1'b1;
                wait_left <= burst_mode ? 0 : $urandom_range(0, 15);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_outcome e;
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result: status %0d page %0h order %0d",
                       o_status, o_result_page, o_final_order);
                errors++;
            end else begin
                e = expected_outcomes.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    errors++;
                end
                if (o_result_page !== e.page) begin
                    $error("result_page: expected %0h, got %0h", e.page, o_result_page);
                    errors++;
                end
                if (o_final_order !== e.order) begin
                    $error("final_order: expected %0d, got %0d", e.order, o_final_order);
                    errors++;
                end
            end
        end
        if ((i_rst_n && o_done) || (start && !busy)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        bit [PAGE_W-1:0] bases[5];
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_data = 0;
        pool_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        // Directed: bad orders, exhaustion, error frees, merges, splits.
        issue(MODE_ALLOC, 15, 0);
        issue(MODE_ALLOC, MAX_ORDER + 1, 0);
        issue(MODE_FREE, 0, 20'hFFFFF);
        issue(MODE_FREE, 0, 0);
        for (int i = 0; i < POOL_PAGES >> MAX_ORDER; i++) issue(MODE_ALLOC, MAX_ORDER, 0);
        issue(MODE_ALLOC, 0, 0);
        free_live(0, 1);
        free_live(0, 0);
        issue(MODE_ALLOC, 0, 0);
        issue(MODE_ALLOC, 0, 0);
        issue(MODE_ALLOC, 3, 0);
        issue(MODE_ALLOC, 3, 0);
        issue(MODE_FREE, 15, PAGE_W'(pool_base + 1));
        while (live_idx.size() != 0) free_live(live_idx.size() - 1, 0);
        issue(MODE_ALLOC, 1, 0);
        burst_mode = 1;
        drain();
        burst_mode = 0;

        bases[0] = 0;
        bases[1] = 20'hFFFFF;
        bases[2] = PAGE_W'(20'hFFFFF - POOL_PAGES + 1);
        bases[3] = PAGE_W'($urandom);
        bases[4] = PAGE_W'($urandom_range(1, 4095));
        for (int p = 0; p < 5; p++) begin
            write_base(bases[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 90 == 0) begin
                    drain();
                    burst_mode = $urandom_range(0, 2) == 0;
                end
                random_item();
            end
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: sim.f
hdl/bpa_pkg.sv
hdl/bpa_datapath.sv
hdl/bpa_ctrl.sv
hdl/buddy_page_allocator_core.sv
tb/tb.sv
